// ===== sv/rjac_pkg.sv =====
// ----------------------------------------------------------------------------
// rjac_pkg
// Shared widths, codes and word types of the radar Jacobian pipeline.
// ----------------------------------------------------------------------------
package rjac_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int SS_W       = 2 * WORD_W;
    localparam int DEN_W      = 3 * WORD_W;
    localparam int NUM_W      = DEN_W + FRAC_BITS;
    localparam int Q_W        = WORD_W + 1;
    localparam int REM_W      = WORD_W + 1;
    localparam int SQRT_STEPS = WORD_W;
    localparam int DIV_LAT    = Q_W + 1;
    localparam int N_DIV      = 6;

    localparam logic [WORD_W-1:0] MIN_RESET = WORD_W'(7);
    localparam logic [WORD_W-1:0] POS_SAT   = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] NEG_SAT   = {1'b1, {(WORD_W-1){1'b0}}};

    // result lanes
    localparam int Q_RANGE_X   = 0;
    localparam int Q_RANGE_Y   = 1;
    localparam int Q_BEARING_X = 2;
    localparam int Q_BEARING_Y = 3;
    localparam int Q_RATE_X    = 4;
    localparam int Q_RATE_Y    = 5;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [WORD_W-1:0] root;
        logic [SS_W-1:0]   x;
    } sqrt_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   num;
        logic [Q_W-1:0]   q;
        logic             ovf;
        logic             zero;
        logic             neg;
    } div_t;

    typedef struct packed {
        logic [SS_W-1:0]   ss;
        logic [WORD_W-1:0] apx;
        logic [WORD_W-1:0] apy;
        logic [SS_W-1:0]   dmag;
        logic [N_DIV-1:0]  neg;
        logic              flag;
    } side_t;

    typedef struct packed {
        logic [N_DIV-1:0][WORD_W-1:0] q;
        logic                         flag;
    } res_t;

endpackage

// ===== sv/rjac_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rjac_sqrt_cell
// One step of the integer square root (two radicand bits in, one root bit out), registered.
// ----------------------------------------------------------------------------
module rjac_sqrt_cell
    import rjac_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t cur,
    output sqrt_t nxt
);

    sqrt_t                nxt_reg;
    sqrt_t                nxt_next;
    logic  [REM_W+1:0]    rem_sh;
    logic  [REM_W+1:0]    trial;
    logic  [REM_W+1:0]    diff;
    logic                 ge;

    always_comb
    begin
        rem_sh = {cur.rem, cur.x[SS_W-1 -: 2]};
        trial  = (REM_W+2)'({cur.root, 2'b01});
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
        nxt_next.rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        nxt_next.root = {cur.root[WORD_W-2:0], ge};
        nxt_next.x    = cur.x << 2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg <= nxt_next;
        end
    end

    assign nxt = nxt_reg;

endmodule

// ===== sv/rjac_div_cell.sv =====
// ----------------------------------------------------------------------------
// rjac_div_cell
// One restoring step of the saturating divider, registered.
// ----------------------------------------------------------------------------
module rjac_div_cell
    import rjac_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  div_t cur,
    output div_t nxt
);

    div_t             nxt_reg;
    div_t             nxt_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        rem_sh   = {cur.rem, cur.num[Q_W-1]};
        diff     = rem_sh - {1'b0, cur.den};
        ge       = (rem_sh >= {1'b0, cur.den});
        nxt_next      = cur;
        nxt_next.rem  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        nxt_next.num  = cur.num << 1;
        nxt_next.q    = {cur.q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg <= nxt_next;
        end
    end

    assign nxt = nxt_reg;

endmodule

// ===== sv/rjac_div.sv =====
// ----------------------------------------------------------------------------
// rjac_div
// Pipelined signed saturating divider: overflow check, chain of step cells,
// sign and saturation on the last cell.
// ----------------------------------------------------------------------------
module rjac_div
    import rjac_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [NUM_W-1:0]         num,
    input  logic [DEN_W-1:0]         den,
    input  logic                     neg,
    output logic signed [WORD_W-1:0] quot
);

    div_t                    setup_reg;
    div_t                    setup_next;
    div_t                    chain [Q_W];
    logic [NUM_W-Q_W-1:0]    hi;
    div_t                    last;
    logic                    big_pos;
    logic                    big_neg;

    always_comb
    begin
        hi              = num[NUM_W-1:Q_W];
        setup_next.rem  = DEN_W'(hi);
        setup_next.den  = den;
        setup_next.num  = num[Q_W-1:0];
        setup_next.q    = '0;
        setup_next.ovf  = (DEN_W'(hi) >= den);
        setup_next.zero = (num == '0);
        setup_next.neg  = neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            setup_reg <= setup_next;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            rjac_div_cell u_cell (.clk(clk), .en(en), .cur(setup_reg), .nxt(chain[k]));
        end
        else
        begin : g_rest
            rjac_div_cell u_cell (.clk(clk), .en(en), .cur(chain[k-1]), .nxt(chain[k]));
        end
    end

    always_comb
    begin
        last    = chain[Q_W-1];
        big_pos = last.ovf || last.q[Q_W-1] || last.q[WORD_W-1];
        big_neg = last.ovf || last.q[Q_W-1]
                  || (last.q[WORD_W-1] && (last.q[WORD_W-2:0] != '0));
        if (last.zero)
        begin
            quot = '0;
        end
        else if (!last.neg)
        begin
            quot = big_pos ? POS_SAT : last.q[WORD_W-1:0];
        end
        else
        begin
            quot = big_neg ? NEG_SAT : WORD_W'(-last.q[WORD_W-1:0]);
        end
    end

endmodule

// ===== sv/radar_jacobian.sv =====
// ----------------------------------------------------------------------------
// radar_jacobian
// Radar measurement Jacobian of an EKF in fixed point: range, bearing and
// range-rate partials with a floor on the squared range.
// ----------------------------------------------------------------------------
//  channel  signals                                   word
//  in       in_valid / in_ready                       pos_x pos_y vel_x vel_y
//  out      out_valid / out_ready                     eight entries, floor_applied
//  cfg      cfg_valid / cfg_ready (always high)       cfg_data = min_range_sq
//
//  One word per cycle sustained while no output stall holds the pipeline; stages from input
//  to output register: 3 front stages, 32 square root cells, 2 partial product stages,
//  34 divider stages (overflow check plus 33 cells), output register.
//  Reset clears valid flags and loads min_range_sq with 7.
//  Output stall: a skid register takes one word; in_ready drops while it is full
//  and the whole pipeline holds.
// ----------------------------------------------------------------------------
module radar_jacobian
    import rjac_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [WORD_W-1:0] pos_x,
    input  logic signed [WORD_W-1:0] pos_y,
    input  logic signed [WORD_W-1:0] vel_x,
    input  logic signed [WORD_W-1:0] vel_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] range_dx,
    output logic signed [WORD_W-1:0] range_dy,
    output logic signed [WORD_W-1:0] bearing_dx,
    output logic signed [WORD_W-1:0] bearing_dy,
    output logic signed [WORD_W-1:0] rate_dx,
    output logic signed [WORD_W-1:0] rate_dy,
    output logic signed [WORD_W-1:0] rate_dvx,
    output logic signed [WORD_W-1:0] rate_dvy,
    output logic                     floor_applied,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [WORD_W-1:0]        cfg_data
);

    logic                     en;
    logic [WORD_W-1:0]        min_reg;

    // stage 0
    logic                     vld0_reg;
    logic signed [WORD_W-1:0] px0_reg, py0_reg, vx0_reg, vy0_reg;
    logic [WORD_W-1:0]        apx0_reg, apy0_reg;

    // stage 1
    logic                     vld1_reg;
    logic [SS_W-1:0]          sqx1_reg, sqy1_reg;
    logic signed [SS_W-1:0]   a1_reg, b1_reg;
    logic [WORD_W-1:0]        apx1_reg, apy1_reg;
    logic                     pxn1_reg, pyn1_reg, pyp1_reg;

    // stage 2
    logic                     vld2_reg;
    side_t                    side2_reg;
    side_t                    side2_next;
    logic [SS_W-1:0]          ss_raw;
    logic [SS_W-1:0]          floor_v;
    logic                     dneg;

    // square root chain
    sqrt_t                    sq_init;
    sqrt_t                    sq [SQRT_STEPS];
    side_t                    side_q_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0]    vld_q_reg;
    logic [WORD_W-1:0]        r;
    side_t                    side_r;

    // partial products
    logic                     vld_m1_reg;
    logic [SS_W-1:0]          pr_lo_reg, pr_hi_reg, py_lo_reg, py_hi_reg, px_lo_reg, px_hi_reg;
    logic [WORD_W-1:0]        r_m1_reg;
    side_t                    side_m1_reg;

    logic                     vld_m2_reg;
    logic [DEN_W-1:0]         den_rate_reg, ny_reg, nx_reg;
    logic [WORD_W-1:0]        r_m2_reg;
    side_t                    side_m2_reg;

    // dividers
    logic [N_DIV-1:0][NUM_W-1:0] num;
    logic [N_DIV-1:0][DEN_W-1:0] den;
    logic [N_DIV-1:0][WORD_W-1:0] quot;
    logic [DIV_LAT-1:0]       vld_d_reg;
    logic [DIV_LAT-1:0]       flag_d_reg;

    // output
    logic                     pipe_fire;
    res_t                     pipe_res;
    res_t                     out_reg, out_next, skid_reg, skid_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;

    assign en        = !skid_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
        end
        else if (cfg_valid)
        begin
            min_reg <= cfg_data;
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg   <= 1'b0;
            vld1_reg   <= 1'b0;
            vld2_reg   <= 1'b0;
            vld_q_reg  <= '0;
            vld_m1_reg <= 1'b0;
            vld_m2_reg <= 1'b0;
            vld_d_reg  <= '0;
        end
        else if (en)
        begin
            vld0_reg   <= in_valid;
            vld1_reg   <= vld0_reg;
            vld2_reg   <= vld1_reg;
            vld_q_reg  <= {vld_q_reg[SQRT_STEPS-2:0], vld2_reg};
            vld_m1_reg <= vld_q_reg[SQRT_STEPS-1];
            vld_m2_reg <= vld_m1_reg;
            vld_d_reg  <= {vld_d_reg[DIV_LAT-2:0], vld_m2_reg};
        end
    end

    // front stages
    always_comb
    begin
        ss_raw  = sqx1_reg + sqy1_reg;
        floor_v = SS_W'(min_reg) << FRAC_BITS;
        dneg    = (a1_reg < b1_reg);
        side2_next.flag = (ss_raw < floor_v);
        side2_next.ss   = side2_next.flag ? floor_v : ss_raw;
        side2_next.dmag = dneg ? SS_W'(b1_reg - a1_reg) : SS_W'(a1_reg - b1_reg);
        side2_next.apx  = apx1_reg;
        side2_next.apy  = apy1_reg;
        side2_next.neg[Q_RANGE_X]   = pxn1_reg;
        side2_next.neg[Q_RANGE_Y]   = pyn1_reg;
        side2_next.neg[Q_BEARING_X] = pyp1_reg;
        side2_next.neg[Q_BEARING_Y] = pxn1_reg;
        side2_next.neg[Q_RATE_X]    = pyn1_reg != dneg;
        side2_next.neg[Q_RATE_Y]    = pxn1_reg == dneg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px0_reg  <= pos_x;
            py0_reg  <= pos_y;
            vx0_reg  <= vel_x;
            vy0_reg  <= vel_y;
            apx0_reg <= pos_x[WORD_W-1] ? WORD_W'(-pos_x) : WORD_W'(pos_x);
            apy0_reg <= pos_y[WORD_W-1] ? WORD_W'(-pos_y) : WORD_W'(pos_y);

            sqx1_reg <= SS_W'(apx0_reg) * SS_W'(apx0_reg);
            sqy1_reg <= SS_W'(apy0_reg) * SS_W'(apy0_reg);
            a1_reg   <= SS_W'(vx0_reg) * SS_W'(py0_reg);
            b1_reg   <= SS_W'(px0_reg) * SS_W'(vy0_reg);
            apx1_reg <= apx0_reg;
            apy1_reg <= apy0_reg;
            pxn1_reg <= px0_reg[WORD_W-1];
            pyn1_reg <= py0_reg[WORD_W-1];
            pyp1_reg <= !py0_reg[WORD_W-1] && (py0_reg != '0);

            side2_reg <= side2_next;
        end
    end

    // square root
    always_comb
    begin
        sq_init.rem  = '0;
        sq_init.root = '0;
        sq_init.x    = side2_reg.ss;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        if (k == 0)
        begin : g_first
            rjac_sqrt_cell u_cell (.clk(clk), .en(en), .cur(sq_init), .nxt(sq[k]));
        end
        else
        begin : g_rest
            rjac_sqrt_cell u_cell (.clk(clk), .en(en), .cur(sq[k-1]), .nxt(sq[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_q_reg[0] <= side2_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                side_q_reg[k] <= side_q_reg[k-1];
            end
        end
    end

    assign r      = sq[SQRT_STEPS-1].root;
    assign side_r = side_q_reg[SQRT_STEPS-1];

    // wide products in two halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_lo_reg   <= SS_W'(side_r.ss[WORD_W-1:0]) * SS_W'(r);
            pr_hi_reg   <= SS_W'(side_r.ss[SS_W-1:WORD_W]) * SS_W'(r);
            py_lo_reg   <= SS_W'(side_r.apy) * SS_W'(side_r.dmag[WORD_W-1:0]);
            py_hi_reg   <= SS_W'(side_r.apy) * SS_W'(side_r.dmag[SS_W-1:WORD_W]);
            px_lo_reg   <= SS_W'(side_r.apx) * SS_W'(side_r.dmag[WORD_W-1:0]);
            px_hi_reg   <= SS_W'(side_r.apx) * SS_W'(side_r.dmag[SS_W-1:WORD_W]);
            r_m1_reg    <= r;
            side_m1_reg <= side_r;

            den_rate_reg <= (DEN_W'(pr_hi_reg) << WORD_W) + DEN_W'(pr_lo_reg);
            ny_reg       <= (DEN_W'(py_hi_reg) << WORD_W) + DEN_W'(py_lo_reg);
            nx_reg       <= (DEN_W'(px_hi_reg) << WORD_W) + DEN_W'(px_lo_reg);
            r_m2_reg     <= r_m1_reg;
            side_m2_reg  <= side_m1_reg;
        end
    end

    always_comb
    begin
        num[Q_RANGE_X]   = NUM_W'(side_m2_reg.apx) << FRAC_BITS;
        num[Q_RANGE_Y]   = NUM_W'(side_m2_reg.apy) << FRAC_BITS;
        num[Q_BEARING_X] = NUM_W'(side_m2_reg.apy) << (2 * FRAC_BITS);
        num[Q_BEARING_Y] = NUM_W'(side_m2_reg.apx) << (2 * FRAC_BITS);
        num[Q_RATE_X]    = NUM_W'(ny_reg) << FRAC_BITS;
        num[Q_RATE_Y]    = NUM_W'(nx_reg) << FRAC_BITS;
        den[Q_RANGE_X]   = DEN_W'(r_m2_reg);
        den[Q_RANGE_Y]   = DEN_W'(r_m2_reg);
        den[Q_BEARING_X] = DEN_W'(side_m2_reg.ss);
        den[Q_BEARING_Y] = DEN_W'(side_m2_reg.ss);
        den[Q_RATE_X]    = den_rate_reg;
        den[Q_RATE_Y]    = den_rate_reg;
    end

    for (genvar j = 0; j < N_DIV; j++)
    begin : g_div
        rjac_div u_div
        (
            .clk  (clk),
            .en   (en),
            .num  (num[j]),
            .den  (den[j]),
            .neg  (side_m2_reg.neg[j]),
            .quot (quot[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag_d_reg <= {flag_d_reg[DIV_LAT-2:0], side_m2_reg.flag};
        end
    end

    // output register and skid
    assign pipe_fire     = en && vld_d_reg[DIV_LAT-1];
    assign pipe_res.q    = quot;
    assign pipe_res.flag = flag_d_reg[DIV_LAT-1];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_fire)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_next       = pipe_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = pipe_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign range_dx      = out_reg.q[Q_RANGE_X];
    assign range_dy      = out_reg.q[Q_RANGE_Y];
    assign bearing_dx    = out_reg.q[Q_BEARING_X];
    assign bearing_dy    = out_reg.q[Q_BEARING_Y];
    assign rate_dx       = out_reg.q[Q_RATE_X];
    assign rate_dy       = out_reg.q[Q_RATE_Y];
    assign rate_dvx      = out_reg.q[Q_RANGE_X];
    assign rate_dvy      = out_reg.q[Q_RANGE_Y];
    assign floor_applied = out_reg.flag;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without output word");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && pipe_fire) |=> skid_valid_reg)
        else $error("word lost on output stall");

    a_floor_value: assert property (@(posedge clk) disable iff (!rst_n)
        (vld2_reg && side2_reg.flag) |-> (side2_reg.ss == (SS_W'(min_reg) << FRAC_BITS)))
        else $error("floored ss differs from floor");

    a_sqrt_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_q_reg[SQRT_STEPS-1] |->
            ((66'(r) * 66'(r) <= 66'(side_r.ss))
             && ((66'(r) + 66'd1) * (66'(r) + 66'd1) > 66'(side_r.ss))))
        else $error("square root out of bounds");

endmodule
